FILE: rtl/raster_op_unit_top_macros.svh
// Assertion macros used by the checker file of the raster-op unit.
`ifndef RASTER_OP_UNIT_TOP_MACROS_SVH
`define RASTER_OP_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ROP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rop_pkg.sv
package rop_pkg;

    // Operation kinds held in the rop_type register.
    typedef enum logic [1:0] {
        ROP_ROP2_PAT = 2'd0,
        ROP_ROP2_SRC = 2'd1,
        ROP_ROP3     = 2'd2,
        ROP_ROP4     = 2'd3
    } t_rop_type;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROP_TYPE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FG_CODE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BG_CODE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSP_EN   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSP_VAL  = 3'd4;

    // Reset values of the configuration registers.
    localparam t_rop_type  RST_ROP_TYPE = ROP_ROP3;
    localparam logic [7:0] RST_CODE     = 8'd204;

    // Index bit positions of the three operands in a truth-table lookup.
    localparam logic [1:0] IDX_BIT_DST  = 2'd0;
    localparam logic [1:0] IDX_BIT_MID  = 2'd1;
    localparam logic [1:0] IDX_BIT_HIGH = 2'd2;

    // True when flipping index bit 'which' changes some reachable table entry.
    function automatic logic rop_depends(input logic [7:0] code, input t_rop_type kind,
                                         input logic [1:0] which);
        logic       narrow;
        logic       dep;
        logic [2:0] j;
        narrow = (kind == ROP_ROP2_PAT) || (kind == ROP_ROP2_SRC);
        dep    = 1'b0;
        for (int i = 0; i < 8; i++) begin
            j = 3'(i) ^ (3'd1 << which);
            if ((!narrow || (i < 4)) && (code[i] != code[j])) begin
                dep = 1'b1;
            end
        end
        if (which == 2'd3 || (narrow && which == IDX_BIT_HIGH)) begin
            dep = 1'b0;
        end
        return dep;
    endfunction

endpackage

FILE: rtl/raster_op_unit_top.sv
// Raster-operation unit of a 2D blitter.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. busy is always low, so one pixel word can be started every cycle.
// Each transaction carries destination, source and pattern words, a mono-source
// flag and the mono bit. Every bit of the words indexes the foreground or
// background truth table to form result_word.
// Result channel: o_done is high for exactly one cycle with result_word,
// write_enable and the uses_source/pattern/destination flags. The result of a
// transaction passes through one input register and then one result register.
// Throughput is one transaction per cycle. The receiver cannot stall; every
// result must be taken in its cycle.
// Configuration: a write with i_cfg_we high updates register i_cfg_idx at once;
// unknown indexes are ignored. Write only while no transaction is in flight.
// Reset (synchronous, active low) restores the register defaults (ROP3, both
// codes 204, transparency off) and drops any transaction in flight.
module raster_op_unit_top
    import rop_pkg::*;
#(
    parameter int DATA_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [DATA_BITS-1:0]     i_dst_word,
    input  logic [DATA_BITS-1:0]     i_src_word,
    input  logic [DATA_BITS-1:0]     i_pat_word,
    input  logic                     i_source_is_mono,
    input  logic                     i_mono_bit,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output logic                     o_done,
    output logic [DATA_BITS-1:0]     o_result_word,
    output logic                     o_write_enable,
    output logic                     o_uses_source,
    output logic                     o_uses_pattern,
    output logic                     o_uses_destination
);

    // Configuration registers.
    t_rop_type  r_rop_type;
    logic [7:0] r_fg_code;
    logic [7:0] r_bg_code;
    logic       r_transp_en;
    logic       r_transp_val;

    // Input register.
    logic                 r_in_valid;
    logic [DATA_BITS-1:0] r_dst;
    logic [DATA_BITS-1:0] r_src;
    logic [DATA_BITS-1:0] r_pat;
    logic                 r_is_mono;
    logic                 r_mono_bit;

    // Result register.
    logic                 r_done;
    logic [DATA_BITS-1:0] r_result;
    logic                 r_we;
    logic                 r_uses_src;
    logic                 r_uses_pat;
    logic                 r_uses_dst;

    logic                 n_we;
    logic                 n_use_fg;
    logic [7:0]           n_code;
    logic [DATA_BITS-1:0] n_result;
    logic                 n_uses_src;
    logic                 n_uses_pat;
    logic                 n_uses_dst;
    logic [1:0]           pat_bit_pos;

    assign busy = 1'b0;

    // Configuration writes; unknown indexes leave everything unchanged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rop_type   <= RST_ROP_TYPE;
            r_fg_code    <= RST_CODE;
            r_bg_code    <= RST_CODE;
            r_transp_en  <= 1'b0;
            r_transp_val <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROP_TYPE:   r_rop_type   <= t_rop_type'(i_cfg_wdata[1:0]);
                CFG_FG_CODE:    r_fg_code    <= i_cfg_wdata[7:0];
                CFG_BG_CODE:    r_bg_code    <= i_cfg_wdata[7:0];
                CFG_TRANSP_EN:  r_transp_en  <= i_cfg_wdata[0];
                CFG_TRANSP_VAL: r_transp_val <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Capture an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_dst      <= i_dst_word;
            r_src      <= i_src_word;
            r_pat      <= i_pat_word;
            r_is_mono  <= i_source_is_mono;
            r_mono_bit <= i_mono_bit;
        end
    end

    // Table choice and write enable from the mono controls.
    always_comb begin
        n_use_fg = !r_is_mono || r_transp_en || r_mono_bit;
        n_we     = !(r_is_mono && r_transp_en && (r_mono_bit == r_transp_val));
        n_code   = n_use_fg ? r_fg_code : r_bg_code;
    end

    // Per-bit truth-table lookup.
    always_comb begin
        for (int b = 0; b < DATA_BITS; b++) begin
            case (r_rop_type)
                ROP_ROP2_PAT: n_result[b] = n_code[{1'b0, r_pat[b], r_dst[b]}];
                ROP_ROP2_SRC: n_result[b] = n_code[{1'b0, r_src[b], r_dst[b]}];
                default:      n_result[b] = n_code[{r_pat[b], r_src[b], r_dst[b]}];
            endcase
        end
    end

    // Operand dependency flags; the background table counts only for ROP4.
    always_comb begin
        pat_bit_pos = (r_rop_type == ROP_ROP2_PAT) ? IDX_BIT_MID : IDX_BIT_HIGH;
        n_uses_src  = (r_rop_type != ROP_ROP2_PAT) &&
                      (rop_depends(r_fg_code, r_rop_type, IDX_BIT_MID) ||
                       ((r_rop_type == ROP_ROP4) &&
                        rop_depends(r_bg_code, r_rop_type, IDX_BIT_MID)));
        n_uses_pat  = (r_rop_type != ROP_ROP2_SRC) &&
                      (rop_depends(r_fg_code, r_rop_type, pat_bit_pos) ||
                       ((r_rop_type == ROP_ROP4) &&
                        rop_depends(r_bg_code, r_rop_type, pat_bit_pos)));
        n_uses_dst  = rop_depends(r_fg_code, r_rop_type, IDX_BIT_DST) ||
                      ((r_rop_type == ROP_ROP4) &&
                       rop_depends(r_bg_code, r_rop_type, IDX_BIT_DST));
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result   <= n_result;
            r_we       <= n_we;
            r_uses_src <= n_uses_src;
            r_uses_pat <= n_uses_pat;
            r_uses_dst <= n_uses_dst;
        end
    end

    assign o_done             = r_done;
    assign o_result_word      = r_result;
    assign o_write_enable     = r_we;
    assign o_uses_source      = r_uses_src;
    assign o_uses_pattern     = r_uses_pat;
    assign o_uses_destination = r_uses_dst;

endmodule

FILE: rtl/rop_checker.sv
`include "raster_op_unit_top_macros.svh"

// Port-level checks of the raster-op unit timing and write-enable behavior.
module rop_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_source_is_mono,
    input logic o_done,
    input logic o_write_enable
);

    // Every accepted transaction is later followed by its result on o_done.
    `ROP_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, start && !busy, ##1 o_done,
                     "result missing two cycles after start")

    // No result appears without an earlier accepted transaction.
    `ROP_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_done,
                    $past(start, 2) && !$past(busy, 2),
                    "result without a started transaction")

    // A suppressed write can only come from a mono source.
    `ROP_ASSERT_NOW(a_we_mono_only, i_clk, i_rst_n, o_done && !o_write_enable,
                    $past(i_source_is_mono, 2), "write suppressed for a non-mono source")

endmodule

bind raster_op_unit_top rop_checker u_rop_checker (.*);
